// File: hw/rtl/tcp_option_parser_defines.svh
// Assertion macros used by the TCP option parser core RTL.
`ifndef TCP_OPTION_PARSER_DEFINES_SVH
`define TCP_OPTION_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TOP_ASSERT_IMPLIES(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication.
`define TOP_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: hw/rtl/tcpop_pkg.sv
// Types and constants shared by the TCP option parser modules.
`default_nettype none
package tcpop_pkg;

   localparam logic [3:0] WSCALE_LIMIT = 4'd14;
   localparam logic [7:0] MIN_OPT_LEN  = 8'd2;

   // option kind codes
   localparam logic [7:0] OPT_EOL = 8'd0;
   localparam logic [7:0] OPT_NOP = 8'd1;
   localparam logic [7:0] OPT_MSS = 8'd2;
   localparam logic [7:0] OPT_WS  = 8'd3;
   localparam logic [7:0] OPT_TS  = 8'd8;

   // fixed option lengths
   localparam logic [7:0] LEN_MSS = 8'd4;
   localparam logic [7:0] LEN_WS  = 8'd3;
   localparam logic [7:0] LEN_TS  = 8'd10;

   // bit positions in the seen-flags vector
   localparam int FLAG_MSS = 0;
   localparam int FLAG_WS  = 1;
   localparam int FLAG_TS  = 2;
   localparam int FLAG_ERR = 3;

   // one registered input word handed to the parse core
   typedef struct packed {
      logic       valid;
      logic       mode;
      logic [7:0] opt_byte;
      logic       last_byte;
   } step_type;

   // one result word
   typedef struct packed {
      logic        status;
      logic        got_mss;
      logic        got_wscale;
      logic        got_tstamp;
      logic [15:0] mss_value;
      logic [3:0]  wscale_value;
      logic [31:0] ts_value;
      logic [31:0] ts_echo;
   } rsp_type;

endpackage
`default_nettype wire

// File: hw/rtl/tcpop_core.sv
// Option parse state, per-byte update logic and the result register.
`default_nettype none
`include "tcp_option_parser_defines.svh"
module tcpop_core
   import tcpop_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire step_type step,
   output logic          out_free,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp
);

   typedef enum logic [2:0] {
      PH_KIND,
      PH_LEN,
      PH_DATA,
      PH_SKIP,
      PH_DONE,
      PH_ERR
   } phase_type;

   typedef enum logic [1:0] {
      K_MSS,
      K_WS,
      K_TS,
      K_OTHER
   } kind_type;

   phase_type   phase_ff, phase_in, phase_step;
   kind_type    kind_ff, kind_in, kind_step;
   logic [7:0]  rem_ff, rem_in, rem_step;
   logic [15:0] mss_ff, mss_in, mss_step;
   logic [3:0]  scale_ff, scale_in, scale_step;
   logic [31:0] tsval_ff, tsval_in, tsval_step;
   logic [31:0] tsecr_ff, tsecr_in, tsecr_step;
   logic [3:0]  flags_ff, flags_in, flags_step;
   logic [7:0]  need;
   logic        emit;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        err;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      phase_step = phase_ff;
      kind_step  = kind_ff;
      rem_step   = rem_ff;
      mss_step   = mss_ff;
      scale_step = scale_ff;
      tsval_step = tsval_ff;
      tsecr_step = tsecr_ff;
      flags_step = flags_ff;
      emit       = 1'b0;
      need       = (kind_ff == K_MSS) ? LEN_MSS : (kind_ff == K_WS) ? LEN_WS : LEN_TS;

      if (step.valid) begin
         if (step.mode) begin
            // empty option area: drop any partial segment, report nothing found
            phase_step = PH_KIND;
            kind_step  = K_MSS;
            rem_step   = '0;
            mss_step   = '0;
            scale_step = '0;
            tsval_step = '0;
            tsecr_step = '0;
            flags_step = '0;
            emit       = 1'b1;
         end else begin
            case (phase_ff)
               PH_KIND: begin
                  if (step.opt_byte == OPT_EOL) begin
                     phase_step = PH_DONE;
                  end else if (step.opt_byte == OPT_NOP) begin
                     phase_step = PH_KIND;
                  end else begin
                     kind_step  = (step.opt_byte == OPT_MSS) ? K_MSS :
                                  (step.opt_byte == OPT_WS)  ? K_WS  :
                                  (step.opt_byte == OPT_TS)  ? K_TS  : K_OTHER;
                     phase_step = PH_LEN;
                  end
               end
               PH_LEN: begin
                  if (kind_ff == K_OTHER) begin
                     if (step.opt_byte < MIN_OPT_LEN) begin
                        flags_step[FLAG_ERR] = 1'b1;
                        phase_step           = PH_ERR;
                     end else if (step.opt_byte == MIN_OPT_LEN) begin
                        phase_step = PH_KIND;
                     end else begin
                        rem_step   = step.opt_byte - MIN_OPT_LEN;
                        phase_step = PH_SKIP;
                     end
                  end else if (step.opt_byte != need) begin
                     flags_step[FLAG_ERR] = 1'b1;
                     phase_step           = PH_ERR;
                  end else begin
                     rem_step   = need - MIN_OPT_LEN;
                     phase_step = PH_DATA;
                  end
               end
               PH_DATA: begin
                  if (kind_ff == K_MSS) begin
                     mss_step = {mss_ff[7:0], step.opt_byte};
                  end else if (kind_ff == K_WS) begin
                     scale_step = (step.opt_byte > {4'd0, WSCALE_LIMIT}) ?
                                  WSCALE_LIMIT : step.opt_byte[3:0];
                  end else if (rem_ff > 8'd4) begin
                     tsval_step = {tsval_ff[23:0], step.opt_byte};
                  end else begin
                     tsecr_step = {tsecr_ff[23:0], step.opt_byte};
                  end
                  rem_step = rem_ff - 8'd1;
                  if (rem_ff == 8'd1) begin
                     case (kind_ff)
                        K_MSS:   flags_step[FLAG_MSS] = 1'b1;
                        K_WS:    flags_step[FLAG_WS]  = 1'b1;
                        default: flags_step[FLAG_TS]  = 1'b1;
                     endcase
                     phase_step = PH_KIND;
                  end
               end
               PH_SKIP: begin
                  rem_step = rem_ff - 8'd1;
                  if (rem_ff == 8'd1) begin
                     phase_step = PH_KIND;
                  end
               end
               default: begin
               end
            endcase

            if (step.last_byte) begin
               // option still open at the end of the area
               if (phase_step == PH_LEN || phase_step == PH_DATA || phase_step == PH_SKIP) begin
                  flags_step[FLAG_ERR] = 1'b1;
               end
               emit = 1'b1;
            end
         end
      end

      err                 = flags_step[FLAG_ERR];
      rsp_in.status       = err;
      rsp_in.got_mss      = !err && flags_step[FLAG_MSS];
      rsp_in.got_wscale   = !err && flags_step[FLAG_WS];
      rsp_in.got_tstamp   = !err && flags_step[FLAG_TS];
      rsp_in.mss_value    = rsp_in.got_mss    ? mss_step   : 16'd0;
      rsp_in.wscale_value = rsp_in.got_wscale ? scale_step : 4'd0;
      rsp_in.ts_value     = rsp_in.got_tstamp ? tsval_step : 32'd0;
      rsp_in.ts_echo      = rsp_in.got_tstamp ? tsecr_step : 32'd0;

      // state goes back to reset values after every result
      if (emit) begin
         phase_in = PH_KIND;
         kind_in  = K_MSS;
         rem_in   = '0;
         mss_in   = '0;
         scale_in = '0;
         tsval_in = '0;
         tsecr_in = '0;
         flags_in = '0;
      end else begin
         phase_in = phase_step;
         kind_in  = kind_step;
         rem_in   = rem_step;
         mss_in   = mss_step;
         scale_in = scale_step;
         tsval_in = tsval_step;
         tsecr_in = tsecr_step;
         flags_in = flags_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_KIND;
         kind_ff      <= K_MSS;
         rem_ff       <= '0;
         mss_ff       <= '0;
         scale_ff     <= '0;
         tsval_ff     <= '0;
         tsecr_ff     <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         rem_ff   <= rem_in;
         mss_ff   <= mss_in;
         scale_ff <= scale_in;
         tsval_ff <= tsval_in;
         tsecr_ff <= tsecr_in;
         flags_ff <= flags_in;
         if (out_free) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_ff <= rsp_in;
      end
   end

   `TOP_ASSERT_IMPLIES(a_err_phase_flag, phase_ff == PH_ERR, flags_ff[FLAG_ERR],
      "error phase without error flag")
   `TOP_ASSERT_IMPLIES(a_data_count, phase_ff == PH_DATA, rem_ff != 8'd0 && rem_ff <= 8'd8,
      "data byte count out of range")
   `TOP_ASSERT_IMPLIES(a_err_clean, rsp_valid_ff && rsp_ff.status,
      !rsp_ff.got_mss && !rsp_ff.got_wscale && !rsp_ff.got_tstamp,
      "error result reports options")
   `TOP_ASSERT_IMPLIES(a_wscale_clamp, rsp_valid_ff, rsp_ff.wscale_value <= WSCALE_LIMIT,
      "window scale above limit")
   `TOP_ASSERT_NEXT(a_end_clears, emit, phase_ff == PH_KIND && flags_ff == 4'd0,
      "state not cleared after result")

endmodule
`default_nettype wire

// File: hw/rtl/tcp_option_parser.sv
// Top level of the TCP header option parser: stream ports and input register.
// Takes the option area of one TCP header one byte per word (tlast on the final
// byte; tuser high for a word that stands for an empty option area) and returns
// one result word per area: error status, which of MSS, window scale and
// timestamp were seen, and their big-endian values (zero unless seen, all zero
// on error). Throughput is one byte per cycle unless stalled; a byte passes an
// input register and then the result register before its result is valid.
// Input and output registers let a new byte be taken while a finished result
// waits, stalling only when both hold a word and the result is not taken.
`default_nettype none
module tcp_option_parser
   import tcpop_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] opt_byte
   input  wire logic        req_tuser,   // [0] mode
   input  wire logic        req_tlast,   // last_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [87:0]      rsp_tdata    // [0] status, [1] got_mss, [2] got_wscale,
                                         // [3] got_tstamp, [19:4] mss_value,
                                         // [23:20] wscale_value, [55:24] ts_value,
                                         // [87:56] ts_echo
);

   logic       in_valid_ff;
   logic       in_mode_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_free;
   step_type   step;
   rsp_type    rsp;

   assign req_tready = !in_valid_ff || out_free;

   assign step.valid     = in_valid_ff && out_free;
   assign step.mode      = in_mode_ff;
   assign step.opt_byte  = in_byte_ff;
   assign step.last_byte = in_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (out_free) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_mode_ff <= req_tuser;
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   tcpop_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .out_free  (out_free),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {rsp.ts_echo, rsp.ts_value, rsp.wscale_value, rsp.mss_value,
                       rsp.got_tstamp, rsp.got_wscale, rsp.got_mss, rsp.status};

endmodule
`default_nettype wire
